// ===== src/hmac_pkg.sv =====
// hmac_pkg: shared types, constants and the rotr round helper for the hmac-sha256 engine
// no dependencies
package hmac_pkg;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [63:0] OUTER_LEN_BITS = 64'd768;
    localparam logic [63:0] INNER_START_BITS = 64'd512;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IPAD_LOAD,
        ST_IPAD_RUN,
        ST_BYTE,
        ST_MSG_LOAD,
        ST_MSG_RUN,
        ST_PAD_BYTE,
        ST_PAD_LOAD,
        ST_PAD_RUN,
        ST_LEN_LOAD,
        ST_IN_RUN,
        ST_OPAD_LOAD,
        ST_OPAD_RUN,
        ST_DIG_LOAD,
        ST_DIG_RUN,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_IPAD,
        LD_OPAD,
        LD_DIGEST,
        LD_LENGTH,
        LD_LEN_ONLY
    } load_t;

    typedef struct packed {
        logic       init_chain;
        logic       init_outer;
        logic       start_run;
        logic       capture;
        logic       put_byte;
        logic       put_pad;
        logic       clear_count;
        logic       set_count;
        logic       save_inner;
        load_t      load;
    } dp_cmd_t;

    typedef struct packed {
        logic       run_done;
        logic [5:0] fill;
    } dp_status_t;

    typedef logic [31:0] k_table_t [64];
    localparam k_table_t ROUND_K = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef logic [31:0] hash_t [8];
    localparam hash_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/hmac_datapath.sv =====
// hmac_datapath: key registers, block buffer, sha-256 round unit and chain values
// depends on hmac_pkg; driven by hmac_ctrl commands
module hmac_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic [7:0]            data_byte,
    input  hmac_pkg::dp_cmd_t     cmd,
    output hmac_pkg::dp_status_t  status,
    output logic [255:0]          tag
);

    logic [63:0]  key_reg [8];
    logic [63:0]  buf_reg [8];
    logic [63:0]  buf_next [8];
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  inner_reg [8];
    logic [7:0]   byte_reg;
    logic [63:0]  count_reg;
    logic [5:0]   round_reg;
    logic         run_reg;
    logic         done_reg;

    logic [5:0]   fill;
    logic [31:0]  s0, s1, wnew, t1, t2, wcur;
    logic [31:0]  blk_word [16];
    logic [63:0]  rep;

    assign fill = count_reg[8:3];
    assign status.run_done = done_reg;
    assign status.fill = fill;

    always_comb begin
        rep = (cmd.load == hmac_pkg::LD_OPAD) ? {8{hmac_pkg::OPAD_BYTE}}
                                              : {8{hmac_pkg::IPAD_BYTE}};
        for (int i = 0; i < 8; i++) begin
            blk_word[2*i] = 32'h0;
            blk_word[2*i+1] = 32'h0;
        end
        case (cmd.load)
            hmac_pkg::LD_IPAD, hmac_pkg::LD_OPAD: begin
                for (int i = 0; i < 8; i++) begin
                    blk_word[2*i] = key_reg[i][63:32] ^ rep[63:32];
                    blk_word[2*i+1] = key_reg[i][31:0] ^ rep[31:0];
                end
            end
            hmac_pkg::LD_DIGEST: begin
                for (int i = 0; i < 8; i++) begin
                    blk_word[i] = inner_reg[i];
                end
                blk_word[8] = 32'h80000000;
                blk_word[14] = hmac_pkg::OUTER_LEN_BITS[63:32];
                blk_word[15] = hmac_pkg::OUTER_LEN_BITS[31:0];
            end
            hmac_pkg::LD_LENGTH: begin
                for (int i = 0; i < 7; i++) begin
                    blk_word[2*i] = buf_reg[i][63:32];
                    blk_word[2*i+1] = buf_reg[i][31:0];
                end
                blk_word[14] = count_reg[63:32];
                blk_word[15] = count_reg[31:0];
            end
            hmac_pkg::LD_LEN_ONLY: begin
                blk_word[14] = count_reg[63:32];
                blk_word[15] = count_reg[31:0];
            end
            default: begin
                for (int i = 0; i < 8; i++) begin
                    blk_word[2*i] = buf_reg[i][63:32];
                    blk_word[2*i+1] = buf_reg[i][31:0];
                end
            end
        endcase
    end

    // byte insert, or pad marker with zeros behind it
    always_comb begin
        buf_next = buf_reg;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                if (cmd.put_byte && (6'(i * 8 + j) == fill)) begin
                    buf_next[i][(7 - j) * 8 +: 8] = byte_reg;
                end
                if (cmd.put_pad && (6'(i * 8 + j) == fill)) begin
                    buf_next[i][(7 - j) * 8 +: 8] = 8'h80;
                end
                if (cmd.put_pad && (6'(i * 8 + j) > fill)) begin
                    buf_next[i][(7 - j) * 8 +: 8] = 8'h00;
                end
            end
        end
    end

    // message schedule and one round per cycle
    always_comb begin
        wcur = w_reg[0];
        s0 = hmac_pkg::rotr(w_reg[1], 7) ^ hmac_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = hmac_pkg::rotr(w_reg[14], 17) ^ hmac_pkg::rotr(w_reg[14], 19)
           ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = v_reg[7] + (hmac_pkg::rotr(v_reg[4], 6) ^ hmac_pkg::rotr(v_reg[4], 11)
           ^ hmac_pkg::rotr(v_reg[4], 25)) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + hmac_pkg::ROUND_K[round_reg] + wcur;
        t2 = (hmac_pkg::rotr(v_reg[0], 2) ^ hmac_pkg::rotr(v_reg[0], 13)
           ^ hmac_pkg::rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            byte_reg <= data_byte;
        end
        if (cmd.put_byte || cmd.put_pad) begin
            buf_reg <= buf_next;
        end
        if (cmd.save_inner) begin
            inner_reg <= h_reg;
        end
        if (cmd.start_run) begin
            w_reg <= blk_word;
            if (cmd.init_outer) begin
                v_reg <= hmac_pkg::INIT_HASH;
            end else begin
                v_reg <= h_reg;
            end
        end else if (run_reg) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                key_reg[i] <= '0;
            end
            h_reg <= hmac_pkg::INIT_HASH;
            count_reg <= '0;
            round_reg <= '0;
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cfg_valid) begin
                key_reg[cfg_index] <= cfg_data;
            end
            if (done_reg) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end else if (cmd.init_chain || cmd.init_outer) begin
                h_reg <= hmac_pkg::INIT_HASH;
            end
            if (cmd.clear_count) begin
                count_reg <= '0;
            end else if (cmd.set_count) begin
                count_reg <= hmac_pkg::INNER_START_BITS;
            end else if (cmd.put_byte) begin
                count_reg <= count_reg + 64'd8;
            end
            if (cmd.start_run) begin
                run_reg <= 1'b1;
                round_reg <= '0;
            end else if (run_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            tag[255 - 32*i -: 32] = h_reg[i];
        end
    end

endmodule

// ===== src/hmac_ctrl.sv =====
// hmac_ctrl: sequencer for inner pad, message blocks, padding, outer hash and tag output
// depends on hmac_pkg; commands hmac_datapath
module hmac_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  in_valid_byte,
    input  logic                  in_last,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [1:0]            out_index,
    input  hmac_pkg::dp_status_t  status,
    output hmac_pkg::dp_cmd_t     cmd
);

    hmac_pkg::state_t state_reg, state_next;
    logic             started_reg, started_next;
    logic             bv_reg, bv_next;
    logic             last_reg, last_next;
    logic             long_reg, long_next;
    logic [1:0]       idx_reg, idx_next;
    logic             ovalid_reg, ovalid_next;

    assign m_tvalid = ovalid_reg;
    assign out_index = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hmac_pkg::ST_IDLE;
            started_reg <= 1'b0;
            bv_reg <= 1'b0;
            last_reg <= 1'b0;
            long_reg <= 1'b0;
            idx_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            started_reg <= started_next;
            bv_reg <= bv_next;
            last_reg <= last_next;
            long_reg <= long_next;
            idx_reg <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        started_next = started_reg;
        bv_next = bv_reg;
        last_next = last_reg;
        long_next = long_reg;
        idx_next = idx_reg;
        ovalid_next = ovalid_reg;
        s_tready = 1'b0;
        cmd = '0;
        cmd.load = hmac_pkg::LD_NONE;
        case (state_reg)
            hmac_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    bv_next = in_valid_byte;
                    last_next = in_last;
                    state_next = started_reg ? hmac_pkg::ST_BYTE : hmac_pkg::ST_IPAD_LOAD;
                end
            end
            hmac_pkg::ST_IPAD_LOAD: begin
                cmd.load = hmac_pkg::LD_IPAD;
                cmd.start_run = 1'b1;
                cmd.set_count = 1'b1;
                started_next = 1'b1;
                state_next = hmac_pkg::ST_IPAD_RUN;
            end
            hmac_pkg::ST_IPAD_RUN: begin
                if (status.run_done) begin
                    state_next = hmac_pkg::ST_BYTE;
                end
            end
            hmac_pkg::ST_BYTE: begin
                if (bv_reg) begin
                    cmd.put_byte = 1'b1;
                    bv_next = 1'b0;
                    if (status.fill == 6'd63) begin
                        state_next = hmac_pkg::ST_MSG_LOAD;
                    end else begin
                        state_next = last_reg ? hmac_pkg::ST_PAD_BYTE : hmac_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = last_reg ? hmac_pkg::ST_PAD_BYTE : hmac_pkg::ST_IDLE;
                end
            end
            hmac_pkg::ST_MSG_LOAD: begin
                cmd.start_run = 1'b1;
                state_next = hmac_pkg::ST_MSG_RUN;
            end
            hmac_pkg::ST_MSG_RUN: begin
                if (status.run_done) begin
                    state_next = last_reg ? hmac_pkg::ST_PAD_BYTE : hmac_pkg::ST_IDLE;
                end
            end
            hmac_pkg::ST_PAD_BYTE: begin
                cmd.put_pad = 1'b1;
                long_next = (status.fill >= 6'd56);
                state_next = (status.fill >= 6'd56) ? hmac_pkg::ST_PAD_LOAD
                                                    : hmac_pkg::ST_LEN_LOAD;
            end
            hmac_pkg::ST_PAD_LOAD: begin
                cmd.start_run = 1'b1;
                state_next = hmac_pkg::ST_PAD_RUN;
            end
            hmac_pkg::ST_PAD_RUN: begin
                if (status.run_done) begin
                    state_next = hmac_pkg::ST_LEN_LOAD;
                end
            end
            hmac_pkg::ST_LEN_LOAD: begin
                cmd.load = long_reg ? hmac_pkg::LD_LEN_ONLY : hmac_pkg::LD_LENGTH;
                cmd.start_run = 1'b1;
                state_next = hmac_pkg::ST_IN_RUN;
            end
            hmac_pkg::ST_IN_RUN: begin
                if (status.run_done) begin
                    state_next = hmac_pkg::ST_OPAD_LOAD;
                end
            end
            hmac_pkg::ST_OPAD_LOAD: begin
                cmd.save_inner = 1'b1;
                cmd.init_outer = 1'b1;
                cmd.load = hmac_pkg::LD_OPAD;
                cmd.start_run = 1'b1;
                state_next = hmac_pkg::ST_OPAD_RUN;
            end
            hmac_pkg::ST_OPAD_RUN: begin
                if (status.run_done) begin
                    state_next = hmac_pkg::ST_DIG_LOAD;
                end
            end
            hmac_pkg::ST_DIG_LOAD: begin
                cmd.load = hmac_pkg::LD_DIGEST;
                cmd.start_run = 1'b1;
                state_next = hmac_pkg::ST_DIG_RUN;
            end
            hmac_pkg::ST_DIG_RUN: begin
                if (status.run_done) begin
                    idx_next = '0;
                    ovalid_next = 1'b1;
                    state_next = hmac_pkg::ST_OUT;
                end
            end
            hmac_pkg::ST_OUT: begin
                if (m_tready) begin
                    if (idx_reg == 2'd3) begin
                        ovalid_next = 1'b0;
                        idx_next = '0;
                        cmd.init_chain = 1'b1;
                        cmd.clear_count = 1'b1;
                        started_next = 1'b0;
                        last_next = 1'b0;
                        state_next = hmac_pkg::ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = hmac_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/hmac_sha256_engine.sv =====
// hmac_sha256_engine: hmac-sha256 over a byte stream, tag out as four 64-bit words
// depends on hmac_pkg, hmac_ctrl, hmac_datapath
// a byte passes through ST_IDLE and ST_BYTE, plus one compression when it completes a 64-byte block
// a first item adds a compression for the inner pad; a last item adds a padding step,
// 3 or 4 compressions and the four result words, one round a cycle
// reset (aresetn low, synchronous) clears keys, chain and counters
module hmac_sha256_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // mac_word
    output logic [1:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    hmac_pkg::dp_cmd_t    cmd;
    hmac_pkg::dp_status_t status;
    logic [255:0]         tag;
    logic [1:0]           out_index;

    assign cfg_ready = 1'b1;
    assign m_tuser = out_index;
    assign m_tlast = (out_index == 2'd3);
    assign m_tdata = tag[255 - 64*out_index -: 64];

    hmac_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_valid_byte (s_tuser),
        .in_last       (s_tlast),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .out_index     (out_index),
        .status        (status),
        .cmd           (cmd)
    );

    hmac_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .tag       (tag)
    );

endmodule
